[hw/rtl/mnp_pkg.sv]
`timescale 1ns / 1ps

package mnp_pkg;

    // command codes
    typedef enum logic [1:0] {
        CMD_NOTE_ON  = 2'd0,
        CMD_NOTE_OFF = 2'd1,
        CMD_FLUSH    = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    // configuration register indexes
    localparam logic REG_FILE_TPQ     = 1'b0;
    localparam logic REG_INTERNAL_TPQ = 1'b1;

    localparam int TICK_W      = 48;
    localparam int KEY_W       = 11;
    localparam int NUM_KEYS    = 2048;
    localparam int MAX_RESULTS = 8;
    localparam int RUN_W       = 4;
    localparam logic [TICK_W-1:0] FLUSH_DURATION = 48'd240;
    localparam logic [6:0] VEL_MAX = 7'd127;
    localparam logic [3:0] CH_MAX  = 4'd15;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_PUSH_WAIT,
        ST_POP_WAIT,
        ST_FLUSH_RD,
        ST_FLUSH_OUT
    } state_t;

    typedef enum logic [1:0] {
        RS_IDLE,
        RS_MUL,
        RS_DIV,
        RS_ROUND
    } rs_state_t;

endpackage

[hw/rtl/mnp_rescale.sv]
`timescale 1ns / 1ps

// round(tick * mul / den): shift-add multiply then restoring divide, one bit per cycle
module mnp_rescale (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [31:0]                tick,
    input  logic [14:0]                den,
    input  logic [15:0]                mul,
    output logic                       busy,
    output logic [mnp_pkg::TICK_W-1:0] result
);

    mnp_pkg::rs_state_t state_reg, state_next;
    logic [5:0]                 cnt_reg, cnt_next;
    logic [mnp_pkg::TICK_W-1:0] acc_reg, acc_next;
    logic [mnp_pkg::TICK_W-1:0] mcand_reg, mcand_next;
    logic [15:0]                mplier_reg, mplier_next;
    logic [15:0]                rem_reg, rem_next;
    logic [14:0]                den_reg, den_next;
    logic [mnp_pkg::TICK_W-1:0] result_reg, result_next;
    logic [16:0]                rem2;
    logic                       ge;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mnp_pkg::RS_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        result_reg <= result_next;
    end

    assign rem2 = {rem_reg, acc_reg[mnp_pkg::TICK_W-1]};
    assign ge   = rem2 >= {2'b00, den_reg};

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        result_next = result_reg;
        unique case (state_reg)
            mnp_pkg::RS_IDLE: begin
                if (start) begin
                    acc_next    = '0;
                    mcand_next  = {16'd0, tick};
                    mplier_next = (mul == 16'd0) ? 16'd1 : mul;
                    den_next    = den;
                    cnt_next    = 6'd15;
                    state_next  = mnp_pkg::RS_MUL;
                end
            end
            mnp_pkg::RS_MUL: begin
                if (mplier_reg[0]) begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[mnp_pkg::TICK_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[15:1]};
                if (cnt_reg == 6'd0) begin
                    cnt_next   = 6'(mnp_pkg::TICK_W - 1);
                    rem_next   = '0;
                    state_next = mnp_pkg::RS_DIV;
                end else begin
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            mnp_pkg::RS_DIV: begin
                rem_next = ge ? 16'(rem2 - {2'b00, den_reg}) : rem2[15:0];
                acc_next = {acc_reg[mnp_pkg::TICK_W-2:0], ge};
                if (cnt_reg == 6'd0) begin
                    state_next = mnp_pkg::RS_ROUND;
                end else begin
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            mnp_pkg::RS_ROUND: begin
                if (den_reg == 15'd0) begin
                    result_next = '0;
                end else if ({rem_reg, 1'b0} >= {2'b00, den_reg}) begin
                    result_next = acc_reg + 48'd1;
                end else begin
                    result_next = acc_reg;
                end
                state_next = mnp_pkg::RS_IDLE;
            end
            default: state_next = mnp_pkg::RS_IDLE;
        endcase
    end

    assign busy   = state_reg != mnp_pkg::RS_IDLE;
    assign result = result_reg;

endmodule

[hw/rtl/midi_note_pairing_core.sv]
`timescale 1ns / 1ps

// midi note pairing core
// input channel s_*: one beat per midi event (note on, note off, flush of one key).
// result channel m_*: one beat per finished note; m_last_of_run marks the last
// note caused by an input beat. push, drop and empty pops give no result beat.
// config port cfg_*: index 0 file ticks per quarter, 1 internal ticks per quarter;
// write only while the core is idle.
// timing: one event is worked on at a time. a note on or note off that runs the
// bit-serial rescale unit (16 multiply steps, 48 divide steps, round) takes the
// next beat only once the rescale is done, and a pop also shows its note then.
// a flush holds the input while it reads and emits its notes, up to 8 notes;
// a dropped push, an empty pop or an unused command frees the input right after
// the lookup state.
// after reset the core sweeps the per-key fill counts to zero, one key per
// cycle over all 2048 keys, with s_ready low; config writes are taken meanwhile.
// a stalled receiver holds the result in the output register; the core still
// takes the next event and only waits when that event has a note to hand over
// while the output register is full.
module midi_note_pairing_core #(
    parameter int STACK_DEPTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_index,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [31:0] s_event_tick,
    input  logic [4:0]  s_midi_channel,
    input  logic [6:0]  s_note_number,
    input  logic [6:0]  s_note_velocity,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [47:0] m_start_tick,
    output logic [47:0] m_duration_ticks,
    output logic [6:0]  m_out_note,
    output logic [6:0]  m_out_velocity,
    output logic [4:0]  m_out_channel,
    output logic        m_last_of_run,
    output logic        m_overflow_seen
);

    localparam int FILL_W     = $clog2(STACK_DEPTH + 1);
    localparam int SLOT_W     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int PEND_DEPTH = mnp_pkg::NUM_KEYS * (2 ** SLOT_W);
    localparam int PEND_W     = mnp_pkg::TICK_W + 7;

    // configuration
    logic [14:0] file_tpq_reg;
    logic [15:0] int_tpq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_tpq_reg <= 15'd96;
            int_tpq_reg  <= 16'd960;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                mnp_pkg::REG_FILE_TPQ:     file_tpq_reg <= cfg_wr_data[14:0];
                mnp_pkg::REG_INTERNAL_TPQ: int_tpq_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // channel clamp and key of the incoming beat
    logic [3:0]                 in_cz;
    logic [mnp_pkg::KEY_W-1:0]  in_key;

    always_comb begin
        if (s_midi_channel == 5'd0) begin
            in_cz = 4'd0;
        end else if (s_midi_channel > 5'd16) begin
            in_cz = mnp_pkg::CH_MAX;
        end else begin
            in_cz = 4'(s_midi_channel - 5'd1);
        end
    end
    assign in_key = {in_cz, s_note_number};

    // captured event
    mnp_pkg::state_t state_reg, state_next;
    logic [1:0]                cmd_reg;
    logic [31:0]               tick_reg;
    logic [3:0]                cz_reg;
    logic [6:0]                note_reg;
    logic [6:0]                vel_reg;
    logic [FILL_W-1:0]         fill_cur_reg, fill_cur_next;
    logic [mnp_pkg::RUN_W-1:0] run_reg, run_next;
    logic                      overflow_reg, overflow_next;
    logic [mnp_pkg::KEY_W-1:0] clr_reg, clr_next;
    logic                      in_fire;

    assign in_fire = s_valid && s_ready;
    assign s_ready = state_reg == mnp_pkg::ST_IDLE;

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            cmd_reg  <= s_command;
            tick_reg <= s_event_tick;
            cz_reg   <= in_cz;
            note_reg <= s_note_number;
            vel_reg  <= s_note_velocity;
        end
    end

    // fill count memory, one entry per key
    logic [FILL_W-1:0]         fill_mem [mnp_pkg::NUM_KEYS];
    logic [FILL_W-1:0]         fill_rdata;
    logic                      fill_we;
    logic [mnp_pkg::KEY_W-1:0] fill_waddr;
    logic [FILL_W-1:0]         fill_wdata;

    always_ff @(posedge aclk) begin
        if (fill_we) begin
            fill_mem[fill_waddr] <= fill_wdata;
        end
        if (in_fire) begin
            fill_rdata <= fill_mem[in_key];
        end
    end

    // rescale unit
    logic                       rs_start;
    logic                       rs_busy;
    logic [mnp_pkg::TICK_W-1:0] rs_result;

    mnp_rescale u_rescale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (rs_start),
        .tick    (tick_reg),
        .den     (file_tpq_reg),
        .mul     (int_tpq_reg),
        .busy    (rs_busy),
        .result  (rs_result)
    );

    // pending entry memory: start tick and velocity per key and slot
    logic [PEND_W-1:0]                pend_mem [PEND_DEPTH];
    logic [PEND_W-1:0]                pend_rdata;
    logic                             pend_we;
    logic                             pend_re;
    logic [mnp_pkg::KEY_W+SLOT_W-1:0] pend_waddr;
    logic [mnp_pkg::KEY_W+SLOT_W-1:0] pend_raddr;

    always_ff @(posedge aclk) begin
        if (pend_we) begin
            pend_mem[pend_waddr] <= {rs_result, vel_reg};
        end
        if (pend_re) begin
            pend_rdata <= pend_mem[pend_raddr];
        end
    end

    // output register
    logic                       out_free;
    logic                       out_load;
    logic                       out_valid_reg;
    logic [mnp_pkg::TICK_W-1:0] out_start_next, out_dur_next;
    logic                       out_last_next;
    logic [mnp_pkg::TICK_W-1:0] out_start_reg, out_dur_reg;
    logic [6:0]                 out_note_reg, out_vel_reg;
    logic [4:0]                 out_ch_reg;
    logic                       out_last_reg, out_ovf_reg;
    logic [mnp_pkg::TICK_W-1:0] pend_start;
    logic [6:0]                 pend_vel;

    assign out_free   = !out_valid_reg || m_ready;
    assign pend_start = pend_rdata[PEND_W-1:7];
    assign pend_vel   = pend_rdata[6:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (out_load) begin
            out_start_reg <= out_start_next;
            out_dur_reg   <= out_dur_next;
            out_note_reg  <= note_reg;
            // velocity clamp to one through 127
            out_vel_reg   <= (pend_vel == 7'd0) ? 7'd1 : pend_vel;
            out_ch_reg    <= {1'b0, cz_reg} + 5'd1;
            out_last_reg  <= out_last_next;
            out_ovf_reg   <= overflow_reg;
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mnp_pkg::ST_CLEAR;
            clr_reg      <= '0;
            overflow_reg <= 1'b0;
            fill_cur_reg <= '0;
            run_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            overflow_reg <= overflow_next;
            fill_cur_reg <= fill_cur_next;
            run_reg      <= run_next;
        end
    end

    logic [FILL_W-1:0] fill_dec;
    logic              is_push;

    assign fill_dec = fill_rdata - FILL_W'(1);
    assign is_push  = (cmd_reg == mnp_pkg::CMD_NOTE_ON) && (vel_reg != 7'd0);

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        overflow_next  = overflow_reg;
        fill_cur_next  = fill_cur_reg;
        run_next       = run_reg;
        fill_we        = 1'b0;
        fill_waddr     = {cz_reg, note_reg};
        fill_wdata     = '0;
        pend_we        = 1'b0;
        pend_re        = 1'b0;
        pend_waddr     = {cz_reg, note_reg, fill_cur_reg[SLOT_W-1:0]};
        pend_raddr     = {cz_reg, note_reg, fill_dec[SLOT_W-1:0]};
        rs_start       = 1'b0;
        out_load       = 1'b0;
        out_start_next = pend_start;
        out_dur_next   = mnp_pkg::FLUSH_DURATION;
        out_last_next  = 1'b1;
        unique case (state_reg)
            mnp_pkg::ST_CLEAR: begin
                // zero one key's fill count per cycle
                fill_we    = 1'b1;
                fill_waddr = clr_reg;
                clr_next   = clr_reg + mnp_pkg::KEY_W'(1);
                if (&clr_reg) begin
                    state_next = mnp_pkg::ST_IDLE;
                end
            end
            mnp_pkg::ST_IDLE: begin
                if (in_fire) begin
                    state_next = mnp_pkg::ST_LOOKUP;
                end
            end
            mnp_pkg::ST_LOOKUP: begin
                fill_cur_next = fill_rdata;
                run_next      = '0;
                state_next    = mnp_pkg::ST_IDLE;
                if (is_push) begin
                    if (fill_rdata >= FILL_W'(STACK_DEPTH)) begin
                        overflow_next = 1'b1;
                    end else begin
                        rs_start   = 1'b1;
                        state_next = mnp_pkg::ST_PUSH_WAIT;
                    end
                end else begin
                    case (cmd_reg) inside
                        mnp_pkg::CMD_NOTE_ON, mnp_pkg::CMD_NOTE_OFF: begin
                            if (fill_rdata != '0) begin
                                rs_start   = 1'b1;
                                fill_we    = 1'b1;
                                fill_wdata = fill_dec;
                                pend_re    = 1'b1;
                                state_next = mnp_pkg::ST_POP_WAIT;
                            end
                        end
                        mnp_pkg::CMD_FLUSH: begin
                            if (fill_rdata != '0) begin
                                state_next = mnp_pkg::ST_FLUSH_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            mnp_pkg::ST_PUSH_WAIT: begin
                if (!rs_busy) begin
                    pend_we    = 1'b1;
                    fill_we    = 1'b1;
                    fill_wdata = fill_cur_reg + FILL_W'(1);
                    state_next = mnp_pkg::ST_IDLE;
                end
            end
            mnp_pkg::ST_POP_WAIT: begin
                out_dur_next = (rs_result > pend_start) ? rs_result - pend_start
                                                        : 48'd1;
                if (!rs_busy && out_free) begin
                    out_load   = 1'b1;
                    state_next = mnp_pkg::ST_IDLE;
                end
            end
            mnp_pkg::ST_FLUSH_RD: begin
                pend_re       = 1'b1;
                pend_raddr    = {cz_reg, note_reg,
                                 fill_cur_reg[SLOT_W-1:0] - SLOT_W'(1)};
                fill_cur_next = fill_cur_reg - FILL_W'(1);
                run_next      = run_reg + mnp_pkg::RUN_W'(1);
                state_next    = mnp_pkg::ST_FLUSH_OUT;
            end
            mnp_pkg::ST_FLUSH_OUT: begin
                out_last_next = (fill_cur_reg == '0) ||
                                (run_reg == mnp_pkg::RUN_W'(mnp_pkg::MAX_RESULTS));
                if (out_free) begin
                    out_load = 1'b1;
                    if (out_last_next) begin
                        fill_we    = 1'b1;
                        fill_wdata = fill_cur_reg;
                        state_next = mnp_pkg::ST_IDLE;
                    end else begin
                        state_next = mnp_pkg::ST_FLUSH_RD;
                    end
                end
            end
            default: state_next = mnp_pkg::ST_IDLE;
        endcase
    end

    assign m_valid          = out_valid_reg;
    assign m_start_tick     = out_start_reg;
    assign m_duration_ticks = out_dur_reg;
    assign m_out_note       = out_note_reg;
    assign m_out_velocity   = out_vel_reg;
    assign m_out_channel    = out_ch_reg;
    assign m_last_of_run    = out_last_reg;
    assign m_overflow_seen  = out_ovf_reg;

`ifndef SYNTHESIS
    // a fill count never goes past the stack depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_we |-> fill_wdata <= FILL_W'(STACK_DEPTH))
        else $error("fill count beyond stack depth");

    // the rescale unit is only started when free
    a_rs_start: assert property (@(posedge aclk) disable iff (!aresetn)
        rs_start |-> !rs_busy)
        else $error("rescale started while busy");

    // a result never overwrites one still waiting
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result register overwritten");

    // every note has a nonzero length
    a_dur_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_duration_ticks != 48'd0)
        else $error("zero duration note");
`endif

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        logic [47:0] start;
        logic [47:0] dur;
        logic [6:0]  note;
        logic [6:0]  vel;
        logic [4:0]  chan;
        logic        last;
        logic        ovf;
    } note_beat_t;

    // scoreboard: pairing predictor plus queue of expected note beats
    class note_pairing_board;
        logic [14:0] file_tpq;
        logic [15:0] int_tpq;
        logic [47:0] start_mem [int];
        logic [6:0]  vel_mem [int];
        int          fill [int];
        logic        ovf;
        note_beat_t  pending_notes[$];
        int          err_count;

        function void clear();
            file_tpq = 15'd96;
            int_tpq = 16'd960;
            start_mem.delete();
            vel_mem.delete();
            fill.delete();
            ovf = 1'b0;
            pending_notes.delete();
            err_count = 0;
        endfunction

        function void set_reg(logic idx, logic [15:0] val);
            if (idx == mnp_pkg::REG_FILE_TPQ) file_tpq = val[14:0];
            else int_tpq = val;
        endfunction

        function logic [47:0] rescale(logic [31:0] tick);
            logic [63:0] prod, q, r, mul;
            if (file_tpq == 0) return 48'd0;
            mul = (int_tpq == 0) ? 64'd1 : 64'(int_tpq);
            prod = 64'(tick) * mul;
            q = prod / file_tpq;
            r = prod % file_tpq;
            if (2 * r >= file_tpq) q++;
            return q[47:0];
        endfunction

        function void push_note(logic [47:0] s, logic [47:0] d, logic [6:0] n,
                                logic [6:0] v, logic [4:0] c, logic l);
            note_beat_t b;
            b.start = s; b.dur = d; b.note = n;
            b.vel = (v == 0) ? 7'd1 : v;
            b.chan = c; b.last = l; b.ovf = ovf;
            pending_notes.insert(pending_notes.size(), b);
        endfunction

        function void note_event(mnp_pkg::cmd_t cmd, logic [31:0] tick, logic [4:0] ch,
                                 logic [6:0] note, logic [6:0] vel);
            logic [3:0]  cz;
            logic [47:0] now, st;
            int key, f, n;
            cz = (ch == 0) ? 4'd0 : ((ch - 1 > 15) ? mnp_pkg::CH_MAX : 4'(ch - 1));
            key = {cz, note};
            f = fill.exists(key) ? fill[key] : 0;
            if (cmd == mnp_pkg::CMD_NOTE_ON && vel != 0) begin
                if (f >= 8) begin
                    ovf = 1'b1;
                    return;
                end
                start_mem[key * 8 + f] = rescale(tick);
                vel_mem[key * 8 + f] = vel;
                fill[key] = f + 1;
            end else if (cmd == mnp_pkg::CMD_NOTE_ON || cmd == mnp_pkg::CMD_NOTE_OFF) begin
                if (f == 0) return;
                f--;
                fill[key] = f;
                now = rescale(tick);
                st = start_mem[key * 8 + f];
                push_note(st, (now > st) ? now - st : 48'd1, note, vel_mem[key * 8 + f],
                          5'(cz) + 5'd1, 1'b1);
            end else if (cmd == mnp_pkg::CMD_FLUSH) begin
                n = 0;
                while (f > 0 && n < mnp_pkg::MAX_RESULTS) begin
                    f--;
                    n++;
                    push_note(start_mem[key * 8 + f], mnp_pkg::FLUSH_DURATION, note,
                              vel_mem[key * 8 + f], 5'(cz) + 5'd1,
                              f == 0 || n == mnp_pkg::MAX_RESULTS);
                end
                fill[key] = f;
            end
        endfunction

        function void check_note(note_beat_t got);
            note_beat_t e;
            if (pending_notes.size() == 0) begin
                $error("unexpected note beat, start %0d", got.start);
                err_count++;
                return;
            end
            e = pending_notes.pop_front();
            if (got.start !== e.start) begin
                $error("start_tick exp %0d got %0d", e.start, got.start); err_count++;
            end
            if (got.dur !== e.dur) begin
                $error("duration_ticks exp %0d got %0d", e.dur, got.dur); err_count++;
            end
            if (got.note !== e.note) begin
                $error("out_note exp %0d got %0d", e.note, got.note); err_count++;
            end
            if (got.vel !== e.vel) begin
                $error("out_velocity exp %0d got %0d", e.vel, got.vel); err_count++;
            end
            if (got.chan !== e.chan) begin
                $error("out_channel exp %0d got %0d", e.chan, got.chan); err_count++;
            end
            if (got.last !== e.last) begin
                $error("last_of_run exp %0d got %0d", e.last, got.last); err_count++;
            end
            if (got.ovf !== e.ovf) begin
                $error("overflow_seen exp %0d got %0d", e.ovf, got.ovf); err_count++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_index = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = '0;
    logic [31:0] s_event_tick = '0;
    logic [4:0]  s_midi_channel = 5'd1;
    logic [6:0]  s_note_number = '0;
    logic [6:0]  s_note_velocity = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [47:0] m_start_tick, m_duration_ticks;
    logic [6:0]  m_out_note, m_out_velocity;
    logic [4:0]  m_out_channel;
    logic        m_last_of_run, m_overflow_seen;

    note_pairing_board board;
    int  idle_cycles = 0;
    bit  hold_sink = 1'b0;   // long receiver hold-off requested
    bit  sink_random = 1'b1;

    always #6 aclk = ~aclk;

    midi_note_pairing_core dut (.*);

    // rising edge: record accepted beats on both sides
    always @(posedge aclk) begin
        note_beat_t b;
        if (aresetn && s_valid && s_ready)
            board.note_event(mnp_pkg::cmd_t'(s_command), s_event_tick, s_midi_channel,
                             s_note_number, s_note_velocity);
        if (aresetn && m_valid && m_ready) begin
            b.start = m_start_tick; b.dur = m_duration_ticks; b.note = m_out_note;
            b.vel = m_out_velocity; b.chan = m_out_channel; b.last = m_last_of_run;
            b.ovf = m_overflow_seen;
            board.check_note(b);
        end
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    // watchdog: longest legit quiet stretch is the clearing sweep or a long hold-off
    always @(posedge aclk) begin
        if (idle_cycles > 20000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: random stalls (mostly short, a few long), a hold-off or always ready
    always @(negedge aclk) begin
        int r;
        if (hold_sink) begin
            m_ready <= 1'b0;
            repeat (600) @(negedge aclk);
            hold_sink = 1'b0;
        end else if (!sink_random) begin
            m_ready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) m_ready <= 1'b1;
            else if (r < 97) m_ready <= 1'b0;
            else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(20, 150)) @(negedge aclk);
            end
        end
    end

    task automatic cfg_write(logic idx, logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        board.set_reg(idx, val);
    endtask

    // offer one event beat, wait for its handshake, then maybe a gap
    task automatic send_event(mnp_pkg::cmd_t cmd, logic [31:0] tick, logic [4:0] ch,
                              logic [6:0] note, logic [6:0] vel, bit gaps);
        int r;
        s_valid <= 1'b1;
        s_command <= cmd;
        s_event_tick <= tick;
        s_midi_channel <= ch;
        s_note_number <= note;
        s_note_velocity <= vel;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        if (gaps) begin
            r = $urandom_range(0, 99);
            if (r >= 50) begin
                s_valid <= 1'b0;
                repeat (r < 95 ? $urandom_range(1, 4) : $urandom_range(30, 200))
                    @(negedge aclk);
            end
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending_notes.size() != 0) @(negedge aclk);
        // pushes and empty pops give no beat: let the rescale finish
        repeat (120) @(negedge aclk);
    endtask

    function automatic logic [4:0] rand_chan();
        int r;
        r = $urandom_range(0, 19);
        return (r < 16) ? 5'(r + 1) : 5'($urandom_range(0, 31));
    endfunction

    // random phrase: note on/off events on a few keys plus flushes and noise
    task automatic random_phrase(int count, bit gaps);
        logic [31:0] t;
        logic [4:0]  ch;
        logic [6:0]  key;
        int r;
        t = $urandom_range(0, 1000);
        ch = rand_chan();
        key = 7'($urandom_range(0, 127));
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            t = (r < 3) ? $urandom() : t + $urandom_range(0, 400);
            if (r < 5) key = 7'($urandom_range(0, 127));
            if (r >= 95) ch = rand_chan();
            if (r < 45)
                send_event(mnp_pkg::CMD_NOTE_ON, t, ch, key,
                           7'($urandom_range(1, 127)), gaps);
            else if (r < 80)
                send_event((r < 70) ? mnp_pkg::CMD_NOTE_OFF : mnp_pkg::CMD_NOTE_ON,
                           t, ch, key,
                           (r < 70) ? 7'($urandom_range(0, 127)) : 7'd0, gaps);
            else if (r < 88)
                send_event(mnp_pkg::CMD_FLUSH, $urandom(), ch, key,
                           7'($urandom_range(0, 127)), gaps);
            else if (r < 91)
                send_event(mnp_pkg::CMD_NONE, $urandom(), ch, key, 7'($urandom()), gaps);
            else
                send_event(mnp_pkg::cmd_t'($urandom_range(0, 1)), $urandom(),
                           5'($urandom()), 7'($urandom()), 7'($urandom()), gaps);
        end
    endtask

    initial begin
        board = new();
        board.clear();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, every command, special cases
        sink_random = 1'b0;
        send_event(mnp_pkg::CMD_NOTE_ON, 32'd0, 5'd1, 7'd0, 7'd127, 1'b0);
        send_event(mnp_pkg::CMD_NOTE_OFF, 32'hFFFF_FFFF, 5'd1, 7'd0, 7'd0, 1'b0);
        send_event(mnp_pkg::CMD_NOTE_OFF, 32'd5, 5'd1, 7'd0, 7'd0, 1'b0);     // empty pop
        send_event(mnp_pkg::CMD_NOTE_ON, 32'd500, 5'd16, 7'd127, 7'd1, 1'b0);
        // off before start
        send_event(mnp_pkg::CMD_NOTE_ON, 32'd100, 5'd16, 7'd127, 7'd0, 1'b0);
        // channel below range
        send_event(mnp_pkg::CMD_NOTE_ON, 32'd10, 5'd0, 7'd64, 7'd42, 1'b0);
        send_event(mnp_pkg::CMD_NOTE_OFF, 32'd20, 5'd31, 7'd64, 7'd0, 1'b0);
        // channel above range
        send_event(mnp_pkg::CMD_NOTE_ON, 32'd10, 5'd31, 7'd64, 7'd85, 1'b0);
        send_event(mnp_pkg::CMD_NOTE_OFF, 32'd40, 5'd16, 7'd64, 7'd0, 1'b0);
        for (int i = 0; i < 9; i++)                                    // overflow on ninth
            send_event(mnp_pkg::CMD_NOTE_ON, 32'(i * 7), 5'd3, 7'd55,
                       7'(i * 14 + 1), 1'b0);
        send_event(mnp_pkg::CMD_FLUSH, 32'hFFFF_FFFF, 5'd3, 7'd55, 7'd127, 1'b0);
        send_event(mnp_pkg::CMD_FLUSH, 32'd0, 5'd3, 7'd55, 7'd0, 1'b0);   // empty flush
        send_event(mnp_pkg::CMD_NONE, 32'hFFFF_FFFF, 5'd3, 7'd55, 7'd127, 1'b0);
        drain();
        sink_random = 1'b1;

        // settings sweep including extremes and zero divisors/multipliers
        cfg_write(mnp_pkg::REG_FILE_TPQ, 16'd1);
        cfg_write(mnp_pkg::REG_INTERNAL_TPQ, 16'hFFFF);
        random_phrase(60, 1'b1);
        drain();
        cfg_write(mnp_pkg::REG_FILE_TPQ, 16'h7FFF);
        cfg_write(mnp_pkg::REG_INTERNAL_TPQ, 16'd1);
        random_phrase(60, 1'b1);
        drain();
        cfg_write(mnp_pkg::REG_FILE_TPQ, 16'd0);
        random_phrase(25, 1'b1);
        drain();
        cfg_write(mnp_pkg::REG_FILE_TPQ, 16'd3);
        cfg_write(mnp_pkg::REG_INTERNAL_TPQ, 16'd0);
        random_phrase(25, 1'b1);
        drain();
        cfg_write(mnp_pkg::REG_FILE_TPQ, 16'($urandom_range(1, 32767)));
        cfg_write(mnp_pkg::REG_INTERNAL_TPQ, 16'($urandom_range(1, 65535)));

        // long receiver hold-off while the sender keeps offering
        @(negedge aclk);
        hold_sink = 1'b1;
        random_phrase(40, 1'b0);
        drain();   // sender pause until every note has come back

        cfg_write(mnp_pkg::REG_FILE_TPQ, 16'd96);
        cfg_write(mnp_pkg::REG_INTERNAL_TPQ, 16'd960);
        random_phrase(240, 1'b1);
        drain();

        if (board.err_count == 0 && board.pending_notes.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
